// ----- sv/vgd_pkg.sv -----
// ----------------------------------------------------------------------------
// vgd_pkg
// Shared types and constants for the voxel grid downsampler.
// ----------------------------------------------------------------------------
package vgd_pkg;

    localparam int COORD_W           = 19;
    localparam int SIZE_W            = 16;
    localparam int KEY_W             = 3 * COORD_W;
    localparam int HASH_C_W          = 27;
    localparam int HASH_W            = COORD_W + HASH_C_W;
    localparam int EPOCH_W           = 4;
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int TDATA_W           = 64;

    localparam logic [SIZE_W-1:0]   VOXEL_SIZE_RST = 16'd100;
    localparam logic [HASH_C_W-1:0] HASH_MUL_X     = 27'd73856093;
    localparam logic [HASH_C_W-1:0] HASH_MUL_Y     = 27'd19349663;
    localparam logic [HASH_C_W-1:0] HASH_MUL_Z     = 27'd83492791;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [KEY_W-1:0]          key_t;
    typedef logic [EPOCH_W-1:0]        epoch_t;

endpackage

// ----- sv/vgd_front.sv -----
// ----------------------------------------------------------------------------
// vgd_front
// Accepts points, floor-divides the coordinates by the voxel size with three
// radix-2 divider lanes, then hashes the voxel key to a home slot.
// ----------------------------------------------------------------------------
module vgd_front
    import vgd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int SLOT_W = $clog2(TABLE_ENTRIES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  coord_t            in_x,
    input  coord_t            in_y,
    input  coord_t            in_z,
    input  logic              in_start,
    input  logic [SIZE_W-1:0] voxel_size,
    output logic              item_valid,
    input  logic              item_ready,
    output coord_t            item_x,
    output coord_t            item_y,
    output coord_t            item_z,
    output logic              item_start,
    output key_t              item_key,
    output logic [SLOT_W-1:0] item_slot
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIV  = 3'd1;
    localparam logic [2:0] F_FIX  = 3'd2;
    localparam logic [2:0] F_MUL  = 3'd3;
    localparam logic [2:0] F_RED  = 3'd4;
    localparam logic [2:0] F_MOD  = 3'd5;
    localparam logic [2:0] F_OUT  = 3'd6;

    localparam bit                TABLE_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [SLOT_W:0]   TABLE_N    = (SLOT_W + 1)'(TABLE_ENTRIES);
    localparam logic [5:0]        DIV_LAST   = 6'(COORD_W - 1);
    localparam logic [5:0]        MOD_LAST   = 6'(HASH_W - 1);

    logic [2:0]          state_reg, state_next;
    logic [5:0]          cnt_reg;
    logic [SIZE_W-1:0]   div_reg;
    logic [COORD_W-1:0]  dvd_reg [3];
    logic [SIZE_W-1:0]   rem_reg [3];
    logic                neg_reg [3];
    logic [COORD_W-1:0]  key_reg [3];
    logic [HASH_W-1:0]   prod_reg [3];
    logic [HASH_W-1:0]   h_reg;
    logic [SLOT_W-1:0]   mrem_reg;
    logic [SLOT_W-1:0]   slot_reg;
    coord_t              px_reg, py_reg, pz_reg;
    logic                start_reg;

    coord_t              pin [3];
    logic [HASH_C_W-1:0] hmul [3];
    logic [HASH_W-1:0]   h_mix;
    logic [SLOT_W:0]     mod_sh;

    assign pin[0]  = in_x;
    assign pin[1]  = in_y;
    assign pin[2]  = in_z;
    assign hmul[0] = HASH_MUL_X;
    assign hmul[1] = HASH_MUL_Y;
    assign hmul[2] = HASH_MUL_Z;

    assign in_ready   = (state_reg == F_IDLE);
    assign item_valid = (state_reg == F_OUT);
    assign item_x     = px_reg;
    assign item_y     = py_reg;
    assign item_z     = pz_reg;
    assign item_start = start_reg;
    assign item_key   = {key_reg[0], key_reg[1], key_reg[2]};
    assign item_slot  = slot_reg;

    assign h_mix  = prod_reg[0] ^ prod_reg[1] ^ prod_reg[2];
    assign mod_sh = {mrem_reg, h_reg[HASH_W-1]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_DIV;
            F_DIV:  if (cnt_reg == DIV_LAST) state_next = F_FIX;
            F_FIX:  state_next = F_MUL;
            F_MUL:  state_next = F_RED;
            F_RED:  state_next = TABLE_POW2 ? F_OUT : F_MOD;
            F_MOD:  if (cnt_reg == MOD_LAST) state_next = F_OUT;
            F_OUT:  if (item_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [SIZE_W:0] sh;
        logic            ge;
        case (state_reg)
            F_IDLE:
            begin
                cnt_reg   <= '0;
                px_reg    <= in_x;
                py_reg    <= in_y;
                pz_reg    <= in_z;
                start_reg <= in_start;
                div_reg   <= (voxel_size == '0) ? SIZE_W'(1) : voxel_size;
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= pin[i][COORD_W-1];
                    dvd_reg[i] <= pin[i][COORD_W-1] ? (~pin[i] + 1'b1) : pin[i];
                    rem_reg[i] <= '0;
                end
            end
            F_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    sh = {rem_reg[i], dvd_reg[i][COORD_W-1]};
                    ge = (sh >= {1'b0, div_reg});
                    rem_reg[i] <= ge ? SIZE_W'(sh - {1'b0, div_reg}) : sh[SIZE_W-1:0];
                    dvd_reg[i] <= {dvd_reg[i][COORD_W-2:0], ge};
                end
            end
            F_FIX:
            begin
                // floor for negatives: -q, or -q-1 when a remainder is left
                for (int i = 0; i < 3; i++)
                begin
                    if (!neg_reg[i])
                        key_reg[i] <= dvd_reg[i];
                    else if (rem_reg[i] != '0)
                        key_reg[i] <= ~dvd_reg[i];
                    else
                        key_reg[i] <= ~dvd_reg[i] + 1'b1;
                end
            end
            F_MUL:
            begin
                for (int i = 0; i < 3; i++)
                    prod_reg[i] <= {{HASH_C_W{1'b0}}, key_reg[i]} *
                                   {{COORD_W{1'b0}}, hmul[i]};
            end
            F_RED:
            begin
                cnt_reg  <= '0;
                h_reg    <= h_mix;
                mrem_reg <= '0;
                slot_reg <= h_mix[SLOT_W-1:0];
            end
            F_MOD:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                h_reg   <= {h_reg[HASH_W-2:0], 1'b0};
                if (mod_sh >= TABLE_N)
                begin
                    mrem_reg <= SLOT_W'(mod_sh - TABLE_N);
                    slot_reg <= SLOT_W'(mod_sh - TABLE_N);
                end
                else
                begin
                    mrem_reg <= mod_sh[SLOT_W-1:0];
                    slot_reg <= mod_sh[SLOT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/vgd_queue.sv -----
// ----------------------------------------------------------------------------
// vgd_queue
// Two-entry queue between the key front end and the table back end.
// ----------------------------------------------------------------------------
module vgd_queue
    import vgd_pkg::*;
#(
    parameter int DATA_W = KEY_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] data_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/vgd_back.sv -----
// ----------------------------------------------------------------------------
// vgd_back
// Occupied-voxel table with linear probing, epoch-tagged entries and the
// output register.
// ----------------------------------------------------------------------------
module vgd_back
    import vgd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int SLOT_W = $clog2(TABLE_ENTRIES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  coord_t            item_x,
    input  coord_t            item_y,
    input  coord_t            item_z,
    input  logic              item_start,
    input  key_t              item_key,
    input  logic [SLOT_W-1:0] item_slot,
    output logic              out_valid,
    input  logic              out_ready,
    output coord_t            out_x,
    output coord_t            out_y,
    output coord_t            out_z,
    output logic              out_overflow
);

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_READ  = 3'd2;
    localparam logic [2:0] B_CMP   = 3'd3;
    localparam logic [2:0] B_EMIT  = 3'd4;

    localparam int                ENTRY_W   = EPOCH_W + KEY_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);
    localparam epoch_t            EPOCH_MAX = '1;

    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [2:0]        state_reg;
    epoch_t            epoch_reg;
    logic [SLOT_W-1:0] clr_addr_reg;
    logic              pend_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] probe_reg;
    coord_t            x_reg, y_reg, z_reg;
    key_t              key_reg;
    logic              ovf_reg;
    logic              out_valid_reg;
    coord_t            out_x_reg, out_y_reg, out_z_reg;
    logic              out_ovf_reg;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               entry_live, entry_hit, out_free;

    assign entry_live = (rd_data_reg[ENTRY_W-1 -: EPOCH_W] == epoch_reg);
    assign entry_hit  = (rd_data_reg[KEY_W-1:0] == key_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign item_ready = (state_reg == B_IDLE);

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign out_overflow = out_ovf_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = {epoch_reg, key_reg};
        if (state_reg == B_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == B_CMP && !entry_live)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            epoch_reg     <= epoch_t'(1);
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    if (clr_addr_reg == SLOT_LAST)
                    begin
                        clr_addr_reg <= '0;
                        pend_reg     <= 1'b0;
                        state_reg    <= pend_reg ? B_READ : B_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                B_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (!item_start)
                        begin
                            state_reg <= B_READ;
                        end
                        else if (epoch_reg == EPOCH_MAX)
                        begin
                            // epoch wrap: wipe the tags before reuse
                            epoch_reg <= epoch_t'(1);
                            pend_reg  <= 1'b1;
                            state_reg <= B_CLEAR;
                        end
                        else
                        begin
                            epoch_reg <= epoch_reg + 1'b1;
                            state_reg <= B_READ;
                        end
                    end
                end
                B_READ:
                begin
                    state_reg <= B_CMP;
                end
                B_CMP:
                begin
                    if (entry_live && entry_hit)
                        state_reg <= B_IDLE;
                    else if (!entry_live || probe_reg == SLOT_LAST)
                        state_reg <= B_EMIT;
                    else
                        state_reg <= B_READ;
                end
                B_EMIT:
                begin
                    if (out_free)
                        state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                x_reg     <= item_x;
                y_reg     <= item_y;
                z_reg     <= item_z;
                key_reg   <= item_key;
                slot_reg  <= item_slot;
                probe_reg <= '0;
            end
            B_CMP:
            begin
                ovf_reg   <= entry_live;
                probe_reg <= probe_reg + 1'b1;
                if (entry_live)
                    slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_x_reg   <= x_reg;
                    out_y_reg   <= y_reg;
                    out_z_reg   <= z_reg;
                    out_ovf_reg <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/voxel_grid_downsample_core.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_downsample_core
// First-point voxel grid downsampler for a stream of 3D points.
// ----------------------------------------------------------------------------
// Points enter on s_axis; tuser marks the start of a cloud, which empties the
// set of occupied voxels. Kept points leave on m_axis with the overflow flag
// in tuser; a point whose voxel is already occupied produces no beat.
// cfg_* writes the voxel size (always ready); write it only while idle.
// Front end: three radix-2 dividers, then key fixup, hash multiply and reduce,
// plus a bit-serial modulo when TABLE_ENTRIES is not a power of two. It
// takes a new point only after the last one has been handed on.
// Back end: a read and a compare state per table probe, then an emit state for
// a kept point, behind a 2-entry queue.
// After reset the table is swept before the first point is looked up; the
// same sweep runs once every 15 clouds when the epoch tag wraps. A stalled
// m_axis holds the result register; the back end and then the queue fill,
// and s_axis_tready is low whenever the front end is busy with a point.
// ----------------------------------------------------------------------------
module voxel_grid_downsample_core
    import vgd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // point_x, point_y, point_z, zero fill
    input  logic [0:0]         s_axis_tuser,   // start_of_cloud
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // kept_x, kept_y, kept_z, zero fill
    output logic [0:0]         m_axis_tuser,   // table_overflow
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int QD_W   = SLOT_W + KEY_W + 3 * COORD_W + 1;

    logic [SIZE_W-1:0] voxel_size_reg;

    logic              f_valid, f_ready, f_start;
    coord_t            f_x, f_y, f_z;
    key_t              f_key;
    logic [SLOT_W-1:0] f_slot;

    logic              b_valid, b_ready;
    logic [QD_W-1:0]   q_in, q_out;

    coord_t            o_x, o_y, o_z;
    logic              o_ovf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            voxel_size_reg <= VOXEL_SIZE_RST;
        else if (cfg_valid)
            voxel_size_reg <= cfg_data;
    end

    vgd_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_x       (s_axis_tdata[COORD_W-1:0]),
        .in_y       (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .in_z       (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .in_start   (s_axis_tuser[0]),
        .voxel_size (voxel_size_reg),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item_x     (f_x),
        .item_y     (f_y),
        .item_z     (f_z),
        .item_start (f_start),
        .item_key   (f_key),
        .item_slot  (f_slot)
    );

    assign q_in = {f_slot, f_key, f_z, f_y, f_x, f_start};

    vgd_queue #(.DATA_W(QD_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    vgd_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (b_valid),
        .item_ready   (b_ready),
        .item_x       (q_out[COORD_W:1]),
        .item_y       (q_out[2*COORD_W:COORD_W+1]),
        .item_z       (q_out[3*COORD_W:2*COORD_W+1]),
        .item_start   (q_out[0]),
        .item_key     (q_out[3*COORD_W+KEY_W:3*COORD_W+1]),
        .item_slot    (q_out[QD_W-1:QD_W-SLOT_W]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_x        (o_x),
        .out_y        (o_y),
        .out_z        (o_z),
        .out_overflow (o_ovf)
    );

    assign m_axis_tdata = {{(TDATA_W - 3 * COORD_W){1'b0}}, o_z, o_y, o_x};
    assign m_axis_tuser = o_ovf;

endmodule
